### rtl/core/vmt_pkg.sv
// ----------------------------------------------------------------------------
// vmt_pkg
// Shared types and constants for the vertex matrix transform pipeline.
// ----------------------------------------------------------------------------
package vmt_pkg;

    // Matrix geometry and stream slot sizes.
    localparam int NUM_ROWS   = 4;
    localparam int NUM_COLS   = 4;
    localparam int SLOT_W     = 32;
    localparam int TDATA_W    = NUM_COLS * SLOT_W;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_LEFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_RIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_LEFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_RIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_LEFT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_RIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW3_LEFT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW3_RIGHT = 3'd7;

    // Load enables for the two register stages of the adder tree.
    typedef struct packed {
        logic pair_en;
        logic total_en;
    } t_sum_en;

    // Load enables for the rounding stage and the saturation stage.
    typedef struct packed {
        logic round_en;
        logic sat_en;
    } t_fin_en;

endpackage

### rtl/core/vmt_mul.sv
// ----------------------------------------------------------------------------
// vmt_mul
// Sixteen parallel signed multipliers: every matrix element times the
// matching vector component, registered.
// ----------------------------------------------------------------------------
module vmt_mul
    import vmt_pkg::*;
#(
    parameter int EW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [EW-1:0] i_mat  [NUM_ROWS][NUM_COLS],
    input  logic signed [EW-1:0] i_vec  [NUM_COLS],
    output logic signed [2*EW-1:0] o_prod [NUM_ROWS][NUM_COLS]
);

    localparam int PW = 2 * EW;

    logic signed [PW-1:0] n_prod [NUM_ROWS][NUM_COLS];
    logic signed [PW-1:0] r_prod [NUM_ROWS][NUM_COLS];

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                n_prod[r][c] = i_mat[r][c] * i_vec[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

### rtl/core/vmt_sum.sv
// ----------------------------------------------------------------------------
// vmt_sum
// Two-level registered adder tree that forms the exact dot product of
// each matrix row from its four products.
// ----------------------------------------------------------------------------
module vmt_sum
    import vmt_pkg::*;
#(
    parameter int EW = 32
) (
    input  logic                     i_clk,
    input  t_sum_en                  i_en,
    input  logic signed [2*EW-1:0]   i_prod [NUM_ROWS][NUM_COLS],
    output logic signed [2*EW+1:0]   o_sum  [NUM_ROWS]
);

    localparam int PW = 2 * EW;
    localparam int SW = PW + 2;

    logic signed [PW:0]   n_pair [NUM_ROWS][2];
    logic signed [PW:0]   r_pair [NUM_ROWS][2];
    logic signed [SW-1:0] n_sum  [NUM_ROWS];
    logic signed [SW-1:0] r_sum  [NUM_ROWS];

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            n_pair[r][0] = (PW+1)'(i_prod[r][0]) + (PW+1)'(i_prod[r][1]);
            n_pair[r][1] = (PW+1)'(i_prod[r][2]) + (PW+1)'(i_prod[r][3]);
            n_sum[r]     = SW'(r_pair[r][0]) + SW'(r_pair[r][1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.pair_en) begin
            r_pair <= n_pair;
        end
        if (i_en.total_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

### rtl/core/vmt_round_sat.sv
// ----------------------------------------------------------------------------
// vmt_round_sat
// Rounds each exact dot product to the output fraction (nearest, halves
// away from zero), then saturates it to the element range.
// ----------------------------------------------------------------------------
module vmt_round_sat
    import vmt_pkg::*;
#(
    parameter int EW = 32,
    parameter int FB = 16
) (
    input  logic                     i_clk,
    input  t_fin_en                  i_en,
    input  logic signed [2*EW+1:0]   i_sum [NUM_ROWS],
    output logic signed [SLOT_W-1:0] o_res [NUM_ROWS]
);

    localparam int SW = 2 * EW + 2;
    localparam int RW = SW + 1 - FB;
    localparam int XW = (RW > EW) ? RW : EW + 1;

    localparam logic signed [SW:0]   HALF    = (SW+1)'(1) << (FB - 1);
    localparam logic signed [EW-1:0] MAX_POS = {1'b0, {(EW-1){1'b1}}};
    localparam logic signed [EW-1:0] MAX_NEG = {1'b1, {(EW-1){1'b0}}};

    logic signed [SW:0]       w_biased [NUM_ROWS];
    logic signed [RW-1:0]     n_rnd    [NUM_ROWS];
    logic signed [RW-1:0]     r_rnd    [NUM_ROWS];
    logic signed [XW-1:0]     w_ext    [NUM_ROWS];
    logic signed [EW-1:0]     w_sat    [NUM_ROWS];
    logic signed [SLOT_W-1:0] n_res    [NUM_ROWS];
    logic signed [SLOT_W-1:0] r_res    [NUM_ROWS];

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            // A negative sum takes half minus one ulp, so the arithmetic
            // shift rounds its magnitude half away from zero.
            w_biased[r] = (SW+1)'(i_sum[r]) + HALF
                          - (SW+1)'(i_sum[r][SW-1]);
            n_rnd[r]    = w_biased[r][SW:FB];

            w_ext[r] = XW'(r_rnd[r]);
            if ((&w_ext[r][XW-1:EW-1]) || !(|w_ext[r][XW-1:EW-1])) begin
                w_sat[r] = w_ext[r][EW-1:0];
            end else if (w_ext[r][XW-1]) begin
                w_sat[r] = MAX_NEG;
            end else begin
                w_sat[r] = MAX_POS;
            end
            n_res[r] = SLOT_W'(w_sat[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.round_en) begin
            r_rnd <= n_rnd;
        end
        if (i_en.sat_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

### rtl/core/vertex_matrix_transform.sv
// ----------------------------------------------------------------------------
// vertex_matrix_transform
// 4x4 matrix times homogeneous vertex, signed fixed point, streaming.
// ----------------------------------------------------------------------------
// The block multiplies each incoming vertex (x, y, z, w) by a 4x4 matrix held
// in eight configuration registers and sends out the transformed vertex. It
// takes one vertex per clock and sends one result per clock while the output
// side accepts results. The input transfer loads the input register, and
// the sixteen parallel multipliers, two adder-tree levels, a rounding adder
// and the saturating output register follow as registered stages. Every
// stage has its own valid bit and a stage loads whenever it is empty or the
// stage after it moves on, so a stall on the output side fills bubbles first
// and back-pressures the input only once all six stages hold data. Each row
// sum is exact, is rounded to nearest with halves away from zero, and is
// clamped to the signed element range. The matrix resets to identity and
// should be rewritten only while no vertex is in flight.
// ----------------------------------------------------------------------------
module vertex_matrix_transform
    import vmt_pkg::*;
#(
    parameter int FRAC_BITS     = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Configuration write port. Each register packs two elements: the lower
    // column in bits 31:0 and the higher column in bits 63:32.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,

    // Input vertex stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [TDATA_W-1:0]    i_s_tdata,   // in_x, in_y, in_z, in_w (32 bits each)

    // Output vertex stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [TDATA_W-1:0]    o_m_tdata    // out_x, out_y, out_z, out_w (32 bits each)
);

    localparam int EW       = ELEMENT_WIDTH;
    localparam int FB       = FRAC_BITS;
    localparam int N_STAGES = 6;

    // One in this fixed-point format, truncated to the element width.
    localparam logic [EW-1:0] ONE = EW'(64'd1 << FB);

    // Stage numbering for the valid chain.
    localparam int ST_IN    = 0;
    localparam int ST_MUL   = 1;
    localparam int ST_PAIR  = 2;
    localparam int ST_TOTAL = 3;
    localparam int ST_ROUND = 4;
    localparam int ST_OUT   = 5;

    logic signed [EW-1:0]     r_mat [NUM_ROWS][NUM_COLS];
    logic signed [EW-1:0]     r_vec [NUM_COLS];
    logic [N_STAGES-1:0]      r_v;
    logic [N_STAGES-1:0]      w_adv;
    logic                     w_in_xfer;
    logic signed [2*EW-1:0]   w_prod [NUM_ROWS][NUM_COLS];
    logic signed [2*EW+1:0]   w_sum  [NUM_ROWS];
    logic signed [SLOT_W-1:0] w_res  [NUM_ROWS];
    t_sum_en                  w_sum_en;
    t_fin_en                  w_fin_en;

    // ------------------------------------------------------------------
    // Matrix registers. Only the low element-width bits of each 32-bit
    // half are kept; the rest of the slot is ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                for (int c = 0; c < NUM_COLS; c++) begin
                    r_mat[r][c] <= (r == c) ? ONE : '0;
                end
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW0_LEFT: begin
                    r_mat[0][0] <= i_cfg_wdata[EW-1:0];
                    r_mat[0][1] <= i_cfg_wdata[SLOT_W +: EW];
                end
                CFG_ROW0_RIGHT: begin
                    r_mat[0][2] <= i_cfg_wdata[EW-1:0];
                    r_mat[0][3] <= i_cfg_wdata[SLOT_W +: EW];
                end
                CFG_ROW1_LEFT: begin
                    r_mat[1][0] <= i_cfg_wdata[EW-1:0];
                    r_mat[1][1] <= i_cfg_wdata[SLOT_W +: EW];
                end
                CFG_ROW1_RIGHT: begin
                    r_mat[1][2] <= i_cfg_wdata[EW-1:0];
                    r_mat[1][3] <= i_cfg_wdata[SLOT_W +: EW];
                end
                CFG_ROW2_LEFT: begin
                    r_mat[2][0] <= i_cfg_wdata[EW-1:0];
                    r_mat[2][1] <= i_cfg_wdata[SLOT_W +: EW];
                end
                CFG_ROW2_RIGHT: begin
                    r_mat[2][2] <= i_cfg_wdata[EW-1:0];
                    r_mat[2][3] <= i_cfg_wdata[SLOT_W +: EW];
                end
                CFG_ROW3_LEFT: begin
                    r_mat[3][0] <= i_cfg_wdata[EW-1:0];
                    r_mat[3][1] <= i_cfg_wdata[SLOT_W +: EW];
                end
                CFG_ROW3_RIGHT: begin
                    r_mat[3][2] <= i_cfg_wdata[EW-1:0];
                    r_mat[3][3] <= i_cfg_wdata[SLOT_W +: EW];
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage may load when it is empty or when
    // its contents move on in the same cycle; the last stage moves on
    // when the downstream side takes the transfer.
    // ------------------------------------------------------------------
    always_comb begin
        w_adv[ST_OUT] = !r_v[ST_OUT] || i_m_tready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    assign o_s_tready = w_adv[ST_IN];
    assign w_in_xfer  = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[ST_IN]) begin
                r_v[ST_IN] <= i_s_tvalid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (w_adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Input register: the low element-width bits of each 32-bit slot.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                r_vec[c] <= i_s_tdata[c*SLOT_W +: EW];
            end
        end
    end

    // Data stages load only when a valid item actually moves into them.
    assign w_sum_en.pair_en  = w_adv[ST_PAIR]  && r_v[ST_MUL];
    assign w_sum_en.total_en = w_adv[ST_TOTAL] && r_v[ST_PAIR];
    assign w_fin_en.round_en = w_adv[ST_ROUND] && r_v[ST_TOTAL];
    assign w_fin_en.sat_en   = w_adv[ST_OUT]   && r_v[ST_ROUND];

    vmt_mul #(
        .EW(EW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (w_adv[ST_MUL] && r_v[ST_IN]),
        .i_mat  (r_mat),
        .i_vec  (r_vec),
        .o_prod (w_prod)
    );

    vmt_sum #(
        .EW(EW)
    ) u_sum (
        .i_clk  (i_clk),
        .i_en   (w_sum_en),
        .i_prod (w_prod),
        .o_sum  (w_sum)
    );

    vmt_round_sat #(
        .EW(EW),
        .FB(FB)
    ) u_round_sat (
        .i_clk (i_clk),
        .i_en  (w_fin_en),
        .i_sum (w_sum),
        .o_res (w_res)
    );

    assign o_m_tvalid = r_v[ST_OUT];
    assign o_m_tdata  = {w_res[3], w_res[2], w_res[1], w_res[0]};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // An empty input stage must always be able to take a transfer.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[ST_IN] |-> o_s_tready)
        else $error("input stage empty but not ready");

    // Back-pressure reaches the input only when every stage is occupied.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_v) && !i_m_tready)
        else $error("input stalled while a bubble exists");

    // A new result can only come from the rounding stage.
    a_out_from_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_v[ST_ROUND]))
        else $error("result appeared without a rounded item behind it");

    // After reset the matrix is identity.
    a_reset_identity: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |->
            r_mat[0][0] == ONE && r_mat[3][3] == ONE && r_mat[0][1] == '0)
        else $error("matrix not identity after reset");

endmodule

### bench/vertex_matrix_transform_test.sv
// ----------------------------------------------------------------------------
// vertex_matrix_transform_test
// Self-checking bench for the 4x4 fixed-point vertex transform.
// ----------------------------------------------------------------------------
// A short list of directed steps comes first. It covers the identity matrix
// after reset, the largest and smallest matrices against the largest and
// smallest vertices, and half-way rounding in both directions. About 650
// random vertices follow under six random matrices, with three idling
// patterns on the two streams. Every output transfer is compared field by
// field with a typed-in result or with the bench's bit-accurate row model.
// ----------------------------------------------------------------------------
module vertex_matrix_transform_test
    import vmt_pkg::*;
;

    localparam int FRAC_BITS   = 16;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 108;
    localparam int HOLD_CYCLES = 48;

    typedef logic signed [SLOT_W-1:0] t_elem;

    // Packed with x in the lowest bits, so a vertex maps straight onto tdata.
    typedef struct packed {
        t_elem w;
        t_elem z;
        t_elem y;
        t_elem x;
    } t_vertex;

    typedef enum logic {STEP_VERTEX, STEP_WRITE} t_step_kind;

    // One row of the directed list: either a register write or a vertex. A
    // vertex row either carries its result typed in or leaves it to the model.
    typedef struct {
        t_step_kind             kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        t_vertex                vtx;
        bit                     known;
        t_vertex                result;
    } t_step;

    localparam t_elem E_MAX = 32'h7FFF_FFFF;
    localparam t_elem E_MIN = 32'h8000_0000;
    localparam t_elem E_ONE = 32'h0001_0000;

    localparam logic [CFG_IDX_W-1:0] ROW_REGS [8] = '{
        CFG_ROW0_LEFT, CFG_ROW0_RIGHT, CFG_ROW1_LEFT, CFG_ROW1_RIGHT,
        CFG_ROW2_LEFT, CFG_ROW2_RIGHT, CFG_ROW3_LEFT, CFG_ROW3_RIGHT
    };

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [TDATA_W-1:0]    i_s_tdata   = '0;   // in_x, in_y, in_z, in_w (32 bits each)
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [TDATA_W-1:0]    o_m_tdata;          // out_x, out_y, out_z, out_w (32 bits each)

    // The bench's own copy of the matrix, updated with every register write.
    t_elem   matrix [NUM_ROWS][NUM_COLS];
    t_vertex expected_vertices [$];
    t_step   directed_steps [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int results_seen  = 0;
    int hold_left     = 0;
    int mismatches    = 0;

    vertex_matrix_transform dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model of the datapath
    // ------------------------------------------------------------------------

    // One row: the four 64-bit products are summed exactly in 68 bits, which
    // cannot overflow. The magnitude is rounded half away from zero, then
    // clamped to the signed 32-bit range. Sums beyond the 64-bit range fall
    // out of the same clamp, so they need no path of their own.
    function automatic t_elem transform_row(int r, t_vertex v);
        logic signed [67:0] acc;
        logic signed [67:0] coef;
        logic signed [67:0] comp;
        logic [67:0]        q;
        t_elem              parts [NUM_COLS];
        logic               neg;
        int                 c;
        parts = '{v.x, v.y, v.z, v.w};
        acc = '0;
        for (c = 0; c < NUM_COLS; c++) begin
            coef = matrix[r][c];
            comp = parts[c];
            acc  = acc + coef * comp;
        end
        neg = acc[67];
        q   = neg ? -acc : acc;
        q   = (q + (68'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (neg) begin
            if (q > 68'h8000_0000) begin
                q = 68'h8000_0000;
            end
            q = -q;
        end else if (q > 68'h7FFF_FFFF) begin
            q = 68'h7FFF_FFFF;
        end
        return t_elem'(q[31:0]);
    endfunction

    function automatic t_vertex transform_vertex(t_vertex v);
        t_vertex res;
        res.x = transform_row(0, v);
        res.y = transform_row(1, v);
        res.z = transform_row(2, v);
        res.w = transform_row(3, v);
        return res;
    endfunction

    function automatic t_vertex vtx(t_elem x, t_elem y, t_elem z, t_elem w);
        t_vertex v;
        v.x = x;
        v.y = y;
        v.z = z;
        v.w = w;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------------

    // Matrix elements: a tame matrix keeps every element within +/-4.0, so
    // that most results stay in range; otherwise the extremes, zero and full
    // 32-bit patterns are mixed in as well.
    function automatic t_elem rand_coef(bit tame);
        if (!tame) begin
            case ($urandom_range(7))
                0: return t_elem'($urandom);
                1: return '0;
                2: return E_MAX;
                3: return E_MIN;
                default: ;
            endcase
        end
        return t_elem'($urandom_range(0, 1 << 19) - (1 << 18));
    endfunction

    // Vertex components: mostly within +/-256.0, now and then an extreme or a
    // full 32-bit pattern, so that every bit of every field takes both values.
    function automatic t_elem rand_comp();
        case ($urandom_range(9))
            0: return t_elem'($urandom);
            1: return $urandom_range(1) ? E_MAX : E_MIN;
            2: return '0;
            3: return E_ONE;
            default: return t_elem'($urandom_range(0, 1 << 25) - (1 << 24));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Directed steps
    // ------------------------------------------------------------------------

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_step s;
        s = '{kind: STEP_WRITE, reg_idx: idx, reg_val: val, vtx: '0, known: 1'b0,
              result: '0};
        directed_steps.push_back(s);
    endfunction

    function automatic void add_vertex(t_vertex v, bit known, t_vertex result);
        t_step s;
        s = '{kind: STEP_VERTEX, reg_idx: '0, reg_val: '0, vtx: v, known: known,
              result: result};
        directed_steps.push_back(s);
    endfunction

    function automatic void build_directed_steps();
        t_vertex v;
        t_vertex sat_hi;
        t_vertex sat_lo;
        sat_hi = vtx(E_MAX, E_MAX, E_MAX, E_MAX);
        sat_lo = vtx(E_MIN, E_MIN, E_MIN, E_MIN);

        // The identity matrix after reset passes every vertex through as is.
        v = vtx('0, '0, '0, '0);
        add_vertex(v, 1'b1, v);
        v = vtx(E_MAX, E_MIN, 32'h0000_0001, 32'hFFFF_FFFF);
        add_vertex(v, 1'b1, v);
        v = vtx(E_MIN, E_MAX, 32'hFFFF_FFFF, 32'h0000_0001);
        add_vertex(v, 1'b1, v);
        v = vtx(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        add_vertex(v, 1'b1, v);

        // Every element at the largest value: sums run past the 64-bit range.
        foreach (ROW_REGS[k]) begin
            add_write(ROW_REGS[k], {E_MAX, E_MAX});
        end
        add_vertex(sat_hi, 1'b1, sat_hi);
        add_vertex(sat_lo, 1'b1, sat_lo);
        add_vertex(vtx(E_MAX, E_MIN, '0, '0), 1'b0, '0);
        add_vertex(vtx(32'h0000_0001, '0, '0, '0), 1'b0, '0);

        // Every element at the smallest value: the signs flip.
        foreach (ROW_REGS[k]) begin
            add_write(ROW_REGS[k], {E_MIN, E_MIN});
        end
        add_vertex(sat_lo, 1'b1, sat_hi);
        add_vertex(sat_hi, 1'b1, sat_lo);

        // Half-way rounding: row 0 scales x by one LSB, row 1 by minus one
        // LSB, row 2 copies y and row 3 halves w.
        add_write(CFG_ROW0_LEFT,  {32'h0, 32'h0000_0001});
        add_write(CFG_ROW0_RIGHT, '0);
        add_write(CFG_ROW1_LEFT,  {32'h0, 32'hFFFF_FFFF});
        add_write(CFG_ROW1_RIGHT, '0);
        add_write(CFG_ROW2_LEFT,  {E_ONE, 32'h0});
        add_write(CFG_ROW2_RIGHT, '0);
        add_write(CFG_ROW3_LEFT,  '0);
        add_write(CFG_ROW3_RIGHT, {32'h0000_8000, 32'h0});
        add_vertex(vtx(32'h0000_8000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003),
                   1'b0, '0);
        add_vertex(vtx(32'h0000_7FFF, 32'hFFFF_8000, '0, 32'hFFFF_FFFF), 1'b0, '0);
        add_vertex(vtx(32'hFFFF_8000, '0, '0, 32'h0000_0001), 1'b0, '0);
        add_vertex(vtx(32'hFFFF_7FFF, E_MAX, E_MIN, 32'hFFFF_FFFD), 1'b0, '0);
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Writes one register once the stream is drained. Back-to-back writes
    // leave the write enable high; the next vertex to be sent lowers it.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        logic [1:0] col;
        i_s_tvalid <= 1'b0;
        while (expected_vertices.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        col = {idx[0], 1'b0};
        matrix[idx[2:1]][col]         = val[31:0];
        matrix[idx[2:1]][col + 2'd1]  = val[63:32];
        @(posedge i_clk);
    endtask

    // Offers one vertex, after a random number of idle cycles, and records its
    // expected result once the transfer has taken place. Valid stays high on
    // return so that a following vertex can go out on the very next cycle.
    task automatic send_vertex(t_vertex v, t_vertex result);
        i_cfg_we <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= v;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        expected_vertices.push_back(result);
    endtask

    // ------------------------------------------------------------------------
    // Output side: checking and back-pressure
    // ------------------------------------------------------------------------

    function automatic void check_field(string name, t_elem want, t_elem got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endfunction

    // Values are sampled at the clock edge, before any of this edge's
    // updates, so a transfer seen here is the one that the edge completes.
    // Twice in the run the receiver refuses transfers for a long stretch
    // while the sender keeps offering, so the pipeline fills up and the
    // input side has to stall.
    always @(posedge i_clk) begin
        t_vertex got;
        t_vertex want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata;
                results_seen++;
                if (expected_vertices.size() == 0) begin
                    $error("output transfer with no vertex outstanding: %h", got);
                    mismatches++;
                end else begin
                    want = expected_vertices.pop_front();
                    check_field("out_x", want.x, got.x);
                    check_field("out_y", want.y, got.y);
                    check_field("out_z", want.z, got.z);
                    check_field("out_w", want.w, got.w);
                end
                if (results_seen == 40 || results_seen == 560) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial begin
        int      r;
        int      c;
        int      ph;
        int      mode;
        t_vertex v;
        t_vertex result;

        // The matrix comes out of reset as identity.
        for (r = 0; r < NUM_ROWS; r++) begin
            for (c = 0; c < NUM_COLS; c++) begin
                matrix[r][c] = (r == c) ? E_ONE : '0;
            end
        end
        build_directed_steps();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 16;
        recv_idle_pct = 66;
        foreach (directed_steps[n]) begin
            if (directed_steps[n].kind == STEP_WRITE) begin
                write_register(directed_steps[n].reg_idx, directed_steps[n].reg_val);
            end else begin
                v      = directed_steps[n].vtx;
                result = directed_steps[n].known ? directed_steps[n].result
                                                 : transform_vertex(v);
                send_vertex(v, result);
            end
        end

        // Random phases, two per idling pattern: the first of each pair under
        // a wild matrix, the second under a tame one.
        for (ph = 0; ph < PHASES; ph++) begin
            mode = ph / 2;
            send_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 66 : 0;
            recv_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 16 : 0;
            foreach (ROW_REGS[k]) begin
                write_register(ROW_REGS[k], {rand_coef(ph[0]), rand_coef(ph[0])});
            end
            repeat (PHASE_ITEMS) begin
                v = vtx(rand_comp(), rand_comp(), rand_comp(), rand_comp());
                send_vertex(v, transform_vertex(v));
            end
        end

        i_s_tvalid <= 1'b0;
        while (expected_vertices.size() != 0) begin
            @(posedge i_clk);
        end
        // Idle long enough for the six-stage pipeline to drain, to catch any stray
        // output transfer.
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && expected_vertices.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: a correct run finishes well before this timeout.
    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### vertex_matrix_transform.f
rtl/core/vmt_pkg.sv
rtl/core/vmt_mul.sv
rtl/core/vmt_sum.sv
rtl/core/vmt_round_sat.sv
rtl/core/vertex_matrix_transform.sv
bench/vertex_matrix_transform_test.sv
